// ===== design/drl_pkg.sv =====
// Shared types and constants for the delimited record lookup block.
`default_nettype none
package drl_pkg;

  // Row lengths up to 64 bytes, plus the full count itself.
  localparam int LEN_W   = 7;
  localparam int REF_MAX = 16;
  localparam int CFG_A_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_A_W-1:0] CFG_SEP      = 3'd0;
  localparam logic [CFG_A_W-1:0] CFG_DELIM    = 3'd1;
  localparam logic [CFG_A_W-1:0] CFG_COLUMN   = 3'd2;
  localparam logic [CFG_A_W-1:0] CFG_REF_LEN  = 3'd3;
  localparam logic [CFG_A_W-1:0] CFG_REF_LOW  = 3'd4;
  localparam logic [CFG_A_W-1:0] CFG_REF_HIGH = 3'd5;

  typedef enum logic [2:0] {
    ST_ROW       = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_UNTERM    = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_FIELD,
    PH_CLOSED,
    PH_GAP,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_LOAD
  } bstate_t;

  typedef struct packed {
    logic [7:0]   sep;
    logic [7:0]   delim;
    logic [3:0]   column;
    logic [4:0]   ref_len;
    logic [127:0] ref_w;
  } cfg_t;

  // One job for the emitter: a single status word or a whole buffered row.
  typedef struct packed {
    status_t          st;
    logic [LEN_W-1:0] len;
  } job_t;

  typedef struct packed {
    logic             en;
    logic [LEN_W-1:0] addr;
    logic [7:0]       data;
  } mem_wr_t;

  typedef struct packed {
    logic pop;
    logic row_done;
  } back_stat_t;

endpackage
`default_nettype wire

// ===== design/delimited_record_lookup.sv =====
// Top level of the delimited record lookup: config registers, parser, queue, emitter.
//
// Usage:
//   in_*  : text words. in_tdata is one text byte, in_tuser is 1 for end of text
//           (in_tdata is then ignored). One word per cycle is taken while scanning and in_tready is high.
//   out_* : result words. out_tdata is the row byte, out_tuser holds status and
//           field end, out_tlast marks the final word of a run. Each end of text
//           yields one status word, or the matched row byte by byte, or nothing
//           after a row was already sent or an overflow reported.
//   cfg_* : write-only registers, to be written only while the block is idle; the block does not enforce it.
// A status word passes through the job queue, then the output register.
// Throughput: one text word per cycle in the parser while in_tready is high; a matched
// row drains byte by byte, each byte a buffer read and then a load of the output
// register, the next byte read only after the last one is loaded. While it drains, the
// input is held off once the parser leaves its done phase (after the closing end of text).
// Back pressure: out_tready low holds the output register; the two-entry job
// queue then fills and in_tready drops.
// Reset (rst_n low, synchronous): registers return to their defaults, parser,
// queue and emitter go idle. The row buffer is not cleared and needs no sweep.
`default_nettype none
module delimited_record_lookup import drl_pkg::*; #(
  parameter int ROW_MAX = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // in_tdata: [7:0] text_byte
  input  wire logic [7:0]         in_tdata,
  // in_tuser: [0] kind
  input  wire logic               in_tuser,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  // out_tdata: [7:0] row_byte
  output logic [7:0]              out_tdata,
  // out_tuser: [2:0] status, [3] field_end
  output logic [3:0]              out_tuser,
  output logic                    out_tlast,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  input  wire logic               cfg_we,
  input  wire logic [CFG_A_W-1:0] cfg_addr,
  input  wire logic [63:0]        cfg_wdata
);

  cfg_t       cfg_r, cfg_nxt;
  logic       q_push, q_full, q_valid;
  job_t       q_data, q_head;
  mem_wr_t    mem_wr;
  back_stat_t bstat;
  status_t    o_status;
  logic       o_fe;

  // Register file
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SEP:      cfg_nxt.sep           = cfg_wdata[7:0];
        CFG_DELIM:    cfg_nxt.delim         = cfg_wdata[7:0];
        CFG_COLUMN:   cfg_nxt.column        = cfg_wdata[3:0];
        CFG_REF_LEN:  cfg_nxt.ref_len       = cfg_wdata[4:0];
        CFG_REF_LOW:  cfg_nxt.ref_w[63:0]   = cfg_wdata;
        CFG_REF_HIGH: cfg_nxt.ref_w[127:64] = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sep     <= 8'd35;
      cfg_r.delim   <= 8'd124;
      cfg_r.column  <= 4'd0;
      cfg_r.ref_len <= 5'd1;
      cfg_r.ref_w   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  drl_front #(.ROW_MAX(ROW_MAX)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_data),
    .mem_wr    (mem_wr),
    .row_done  (bstat.row_done)
  );

  drl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head),
    .pop       (bstat.pop)
  );

  drl_back #(.ROW_MAX(ROW_MAX)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .sep        (cfg_r.sep),
    .mem_wr     (mem_wr),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .stat       (bstat),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (o_status),
    .out_byte   (out_tdata),
    .out_fe     (o_fe),
    .out_last   (out_tlast)
  );

  assign out_tuser = {o_fe, o_status};

endmodule
`default_nettype wire

// ===== design/drl_front.sv =====
// Parser: accepts text words, tracks fields, fills the row buffer, queues jobs.
`default_nettype none
module drl_front import drl_pkg::*; #(
  parameter int ROW_MAX = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,
  input  wire logic       in_tuser,
  input  wire logic       q_full,
  output logic            q_push,
  output job_t            q_data,
  output mem_wr_t         mem_wr,
  input  wire logic       row_done
);

  phase_t           phase_r, phase_nxt;
  logic [LEN_W-1:0] row_len_r, row_len_nxt;
  logic [4:0]       fidx_r, fidx_nxt;
  logic [6:0]       flen_r, flen_nxt;
  logic             still_r, still_nxt;
  logic             matched_r, matched_nxt;
  logic             seen_r, seen_nxt;
  logic             row_out_r, row_out_nxt;

  logic       acc, eof, is_delim, is_sep, col_hit, buf_full;
  logic [4:0] eff_len;
  logic [7:0] ref_b;

  // No new row may be written while the emitter still reads the old one.
  assign in_tready = !q_full && !(row_out_r && phase_r != PH_DONE);
  assign acc       = in_tvalid && in_tready;
  assign eof       = in_tuser;

  always_comb begin
    is_delim = in_tdata == cfg.delim;
    is_sep   = in_tdata == cfg.sep;
    col_hit  = fidx_r == {1'b0, cfg.column};
    buf_full = row_len_r >= LEN_W'(ROW_MAX);
    eff_len  = (cfg.ref_len > 5'(REF_MAX)) ? 5'(REF_MAX) : cfg.ref_len;
    ref_b    = cfg.ref_w[{flen_r[3:0], 3'b000} +: 8];
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      if (eof) begin
        phase_nxt = PH_WAIT;
      end else begin
        unique case (phase_r)
          PH_WAIT: begin
            if (is_delim) phase_nxt = PH_FIELD;
          end
          PH_FIELD: begin
            if (is_delim)      phase_nxt = PH_CLOSED;
            else if (buf_full) phase_nxt = PH_DONE;
          end
          PH_CLOSED: begin
            if (is_sep)         phase_nxt = buf_full ? PH_DONE : PH_GAP;
            else if (matched_r) phase_nxt = PH_DONE;
            else if (is_delim)  phase_nxt = PH_FIELD;
            else                phase_nxt = PH_WAIT;
          end
          PH_GAP: begin
            if (is_delim)      phase_nxt = PH_FIELD;
            else if (buf_full) phase_nxt = PH_DONE;
          end
          PH_DONE: phase_nxt = PH_DONE;
          default: phase_nxt = PH_WAIT;
        endcase
      end
    end
  end

  // Row counters, compare state and outputs
  always_comb begin
    row_len_nxt = row_len_r;
    fidx_nxt    = fidx_r;
    flen_nxt    = flen_r;
    still_nxt   = still_r;
    matched_nxt = matched_r;
    seen_nxt    = seen_r;
    row_out_nxt = row_done ? 1'b0 : row_out_r;
    q_push      = 1'b0;
    q_data.st   = ST_NOT_FOUND;
    q_data.len  = row_len_r;
    mem_wr.en   = 1'b0;
    mem_wr.addr = row_len_r;
    mem_wr.data = in_tdata;
    if (acc) begin
      if (eof) begin
        q_push = 1'b1;
        priority if (!seen_r) begin
          q_data.st = ST_EMPTY;
        end else if (phase_r == PH_DONE) begin
          q_push = 1'b0;
        end else if (phase_r == PH_FIELD) begin
          q_data.st = ST_UNTERM;
        end else if (matched_r && (phase_r == PH_CLOSED || phase_r == PH_GAP)) begin
          q_data.st   = ST_ROW;
          row_out_nxt = 1'b1;
        end else begin
          q_data.st = ST_NOT_FOUND;
        end
        row_len_nxt = '0;
        fidx_nxt    = '0;
        flen_nxt    = '0;
        still_nxt   = 1'b1;
        matched_nxt = 1'b0;
        seen_nxt    = 1'b0;
      end else begin
        seen_nxt = 1'b1;
        unique case (phase_r)
          PH_WAIT: begin
            if (is_delim) begin
              row_len_nxt = '0;
              fidx_nxt    = '0;
              flen_nxt    = '0;
              still_nxt   = 1'b1;
            end
          end
          PH_FIELD: begin
            if (is_delim) begin
              if (!matched_r && col_hit)
                matched_nxt = still_r && (eff_len != 5'd0) && (flen_r == {2'b00, eff_len});
            end else if (buf_full) begin
              q_push    = 1'b1;
              q_data.st = ST_OVERFLOW;
            end else begin
              mem_wr.en   = 1'b1;
              row_len_nxt = row_len_r + 1'b1;
              if (col_hit) begin
                if (flen_r < {2'b00, eff_len}) begin
                  if (ref_b != in_tdata) still_nxt = 1'b0;
                end else begin
                  still_nxt = 1'b0;
                end
              end
              if (flen_r != 7'd127) flen_nxt = flen_r + 1'b1;
            end
          end
          PH_CLOSED: begin
            if (is_sep) begin
              if (buf_full) begin
                q_push    = 1'b1;
                q_data.st = ST_OVERFLOW;
              end else begin
                mem_wr.en   = 1'b1;
                row_len_nxt = row_len_r + 1'b1;
                if (fidx_r != 5'd31) fidx_nxt = fidx_r + 1'b1;
                flen_nxt  = '0;
                still_nxt = 1'b1;
              end
            end else if (matched_r) begin
              q_push      = 1'b1;
              q_data.st   = ST_ROW;
              row_out_nxt = 1'b1;
            end else begin
              row_len_nxt = '0;
              fidx_nxt    = '0;
              flen_nxt    = '0;
              still_nxt   = 1'b1;
            end
          end
          PH_GAP: begin
            if (!is_delim) begin
              if (buf_full) begin
                q_push    = 1'b1;
                q_data.st = ST_OVERFLOW;
              end else begin
                mem_wr.en   = 1'b1;
                row_len_nxt = row_len_r + 1'b1;
              end
            end
          end
          PH_DONE: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_WAIT;
      row_len_r <= '0;
      fidx_r    <= '0;
      flen_r    <= '0;
      still_r   <= 1'b1;
      matched_r <= 1'b0;
      seen_r    <= 1'b0;
      row_out_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      row_len_r <= row_len_nxt;
      fidx_r    <= fidx_nxt;
      flen_r    <= flen_nxt;
      still_r   <= still_nxt;
      matched_r <= matched_nxt;
      seen_r    <= seen_nxt;
      row_out_r <= row_out_nxt;
    end
  end

  a_no_write_while_draining: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr.en |-> !row_out_r)
    else $error("row buffer written while a row is being emitted");

  a_len_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    row_len_r <= LEN_W'(ROW_MAX))
    else $error("row length beyond buffer depth");

endmodule
`default_nettype wire

// ===== design/drl_queue.sv =====
// Two-entry job queue between parser and emitter.
`default_nettype none
module drl_queue import drl_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_data,
  output logic      full,
  output logic      valid,
  output job_t      head,
  input  wire logic pop
);

  job_t       mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = cnt_r == 2'd2;
  assign valid   = cnt_r != 2'd0;
  assign head    = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop  ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("job pushed into a full queue");

endmodule
`default_nettype wire

// ===== design/drl_back.sv =====
// Emitter: holds the row buffer and drives result words from queued jobs.
`default_nettype none
module drl_back import drl_pkg::*; #(
  parameter int ROW_MAX = 64
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic [7:0] sep,
  input  wire mem_wr_t mem_wr,
  input  wire logic    q_valid,
  input  wire job_t    q_head,
  output back_stat_t   stat,
  output logic         out_valid,
  input  wire logic    out_ready,
  output status_t      out_status,
  output logic [7:0]   out_byte,
  output logic         out_fe,
  output logic         out_last
);

  localparam int AW = $clog2(ROW_MAX);

  logic [7:0] buf_mem [ROW_MAX];
  logic [7:0] rdata_r;

  bstate_t          st_r, st_nxt;
  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic             ov_r, ov_nxt;
  status_t          os_r, os_nxt;
  logic [7:0]       ob_r, ob_nxt;
  logic             ofe_r, ofe_nxt;
  logic             ol_r, ol_nxt;
  logic             out_free, is_row, last_byte;

  always_ff @(posedge clk) begin
    if (mem_wr.en) buf_mem[mem_wr.addr[AW-1:0]] <= mem_wr.data;
    rdata_r <= buf_mem[idx_r[AW-1:0]];
  end

  assign out_free  = !ov_r || out_ready;
  assign is_row    = q_head.st == ST_ROW;
  assign last_byte = (idx_r + 1'b1) == q_head.len;

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      B_IDLE: begin
        if (q_valid && is_row && q_head.len != '0) st_nxt = B_READ;
      end
      B_READ: st_nxt = B_LOAD;
      B_LOAD: begin
        if (out_free) st_nxt = last_byte ? B_IDLE : B_READ;
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    idx_nxt       = idx_r;
    ov_nxt        = ov_r && !out_ready;
    os_nxt        = os_r;
    ob_nxt        = ob_r;
    ofe_nxt       = ofe_r;
    ol_nxt        = ol_r;
    stat.pop      = 1'b0;
    stat.row_done = 1'b0;
    unique case (st_r)
      B_IDLE: begin
        if (q_valid) begin
          if (is_row) begin
            idx_nxt = '0;
            if (q_head.len == '0) begin
              stat.pop      = 1'b1;
              stat.row_done = 1'b1;
            end
          end else if (out_free) begin
            stat.pop = 1'b1;
            ov_nxt   = 1'b1;
            os_nxt   = q_head.st;
            ob_nxt   = '0;
            ofe_nxt  = 1'b0;
            ol_nxt   = 1'b1;
          end
        end
      end
      B_READ: begin
      end
      B_LOAD: begin
        if (out_free) begin
          ov_nxt  = 1'b1;
          os_nxt  = ST_ROW;
          ob_nxt  = rdata_r;
          ofe_nxt = rdata_r == sep;
          ol_nxt  = last_byte;
          if (last_byte) begin
            stat.pop      = 1'b1;
            stat.row_done = 1'b1;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    os_r  <= os_nxt;
    ob_r  <= ob_nxt;
    ofe_r <= ofe_nxt;
    ol_r  <= ol_nxt;
    idx_r <= idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  assign out_valid  = ov_r;
  assign out_status = os_r;
  assign out_byte   = ob_r;
  assign out_fe     = ofe_r;
  assign out_last   = ol_r;

  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && os_r != ST_ROW) |-> (ol_r && ob_r == 8'd0))
    else $error("status word not marked last");

  a_row_job_held: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != B_IDLE) |-> (q_valid && is_row))
    else $error("emitter busy without a row job at the queue head");

endmodule
`default_nettype wire

// ===== tb/sv/drl_lookup_checker.sv =====
// Checker for the delimited record lookup: follows config writes, works out the result words, compares.
module drl_lookup_checker import drl_pkg::*; #(
  parameter int ROW_MAX = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [7:0]         in_tdata,
  input  wire logic               in_tuser,
  input  wire logic               in_tvalid,
  input  wire logic               in_tready,
  input  wire logic [7:0]         out_tdata,
  input  wire logic [3:0]         out_tuser,
  input  wire logic               out_tlast,
  input  wire logic               out_tvalid,
  input  wire logic               out_tready,
  input  wire logic               cfg_we,
  input  wire logic [CFG_A_W-1:0] cfg_addr,
  input  wire logic [63:0]        cfg_wdata,
  output int unsigned             fail_count,
  output int unsigned             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] SEP_RESET   = 8'd35;
  localparam logic [7:0] DELIM_RESET = 8'd124;
  localparam int unsigned FLD_LEN_CAP = 127;
  localparam int unsigned FLD_IDX_CAP = 31;

  typedef struct packed {
    status_t    st;
    logic [7:0] b;
    logic       fe;
    logic       last;
  } lookup_word_t;

  lookup_word_t lookup_words[$];

  // register copy
  logic [7:0]   sep_c, delim_c;
  logic [3:0]   col_c;
  logic [4:0]   rlen_c;
  logic [127:0] ref_c;

  // scan state
  logic [7:0]  row_mem [ROW_MAX];
  int unsigned row_n, fld_idx, fld_n;
  logic        still_eq, hit, any_text;
  phase_t      ph;

  function automatic int unsigned ref_used();
    return (rlen_c > REF_MAX) ? REF_MAX : rlen_c;
  endfunction

  task automatic post(status_t st, logic [7:0] b, logic fe, logic last);
    lookup_words.push_back('{st: st, b: b, fe: fe, last: last});
  endtask

  task automatic clear_scan();
    row_n    = 0;
    fld_idx  = 0;
    fld_n    = 0;
    still_eq = 1'b1;
    hit      = 1'b0;
    ph       = PH_WAIT;
    any_text = 1'b0;
  endtask

  task automatic open_row();
    row_n    = 0;
    fld_idx  = 0;
    fld_n    = 0;
    still_eq = 1'b1;
    ph       = PH_FIELD;
  endtask

  task automatic send_row();
    for (int unsigned i = 0; i < row_n; i++)
      post(ST_ROW, row_mem[i], row_mem[i] == sep_c, i + 1 == row_n);
    ph = PH_DONE;
  endtask

  task automatic overflow_word();
    post(ST_OVERFLOW, 8'h00, 1'b0, 1'b1);
    ph = PH_DONE;
  endtask

  // false when the row buffer is already full
  function automatic bit store(logic [7:0] b);
    if (row_n >= ROW_MAX) return 1'b0;
    row_mem[row_n] = b;
    row_n++;
    return 1'b1;
  endfunction

  task automatic scan_word(logic kind, logic [7:0] b);
    if (kind) begin
      if (!any_text) post(ST_EMPTY, 8'h00, 1'b0, 1'b1);
      else if (ph == PH_DONE) ;
      else if (ph == PH_FIELD) post(ST_UNTERM, 8'h00, 1'b0, 1'b1);
      else if (hit && (ph == PH_CLOSED || ph == PH_GAP)) send_row();
      else post(ST_NOT_FOUND, 8'h00, 1'b0, 1'b1);
      clear_scan();
    end else begin
      any_text = 1'b1;
      case (ph)
        PH_WAIT: begin
          if (b == delim_c) open_row();
        end
        PH_FIELD: begin
          if (b == delim_c) begin
            if (!hit && fld_idx == col_c)
              hit = still_eq && ref_used() != 0 && fld_n == ref_used();
            ph = PH_CLOSED;
          end else if (!store(b)) begin
            overflow_word();
          end else begin
            if (fld_idx == col_c) begin
              if (fld_n < ref_used()) begin
                if (ref_c[fld_n*8 +: 8] != b) still_eq = 1'b0;
              end else begin
                still_eq = 1'b0;
              end
            end
            if (fld_n < FLD_LEN_CAP) fld_n++;
          end
        end
        PH_CLOSED: begin
          if (b == sep_c) begin
            if (!store(b)) begin
              overflow_word();
            end else begin
              if (fld_idx < FLD_IDX_CAP) fld_idx++;
              fld_n    = 0;
              still_eq = 1'b1;
              ph       = PH_GAP;
            end
          end else if (hit) begin
            send_row();
          end else if (b == delim_c) begin
            open_row();
          end else begin
            row_n    = 0;
            fld_idx  = 0;
            fld_n    = 0;
            still_eq = 1'b1;
            ph       = PH_WAIT;
          end
        end
        PH_GAP: begin
          if (b == delim_c) ph = PH_FIELD;
          else if (!store(b)) overflow_word();
        end
        default: ;
      endcase
    end
  endtask

  always @(posedge clk) begin
    lookup_word_t want, got;
    if (!rst_n) begin
      sep_c   = SEP_RESET;
      delim_c = DELIM_RESET;
      col_c   = '0;
      rlen_c  = 5'd1;
      ref_c   = '0;
      clear_scan();
      lookup_words.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_SEP:      sep_c   = cfg_wdata[7:0];
          CFG_DELIM:    delim_c = cfg_wdata[7:0];
          CFG_COLUMN:   col_c   = cfg_wdata[3:0];
          CFG_REF_LEN:  rlen_c  = cfg_wdata[4:0];
          CFG_REF_LOW:  ref_c[63:0]   = cfg_wdata;
          CFG_REF_HIGH: ref_c[127:64] = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.st   = status_t'(out_tuser[2:0]);
        got.b    = out_tdata;
        got.fe   = out_tuser[3];
        got.last = out_tlast;
        if (lookup_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected word status %0d byte %h field_end %b last %b",
                     $time, got.st, got.b, got.fe, got.last);
        end else begin
          want = lookup_words.pop_front();
          if (got.st !== want.st || got.b !== want.b || got.fe !== want.fe ||
              got.last !== want.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch (exp/got) status %0d/%0d byte %h/%h field_end %b/%b last %b/%b",
                       $time, want.st, got.st, want.b, got.b, want.fe, got.fe,
                       want.last, got.last);
          end
        end
      end
      if (in_tvalid && in_tready) scan_word(in_tuser, in_tdata);
    end
    pending = lookup_words.size();
  end

endmodule

// ===== tb/sv/delimited_record_lookup_test.sv =====
// Testbench top for the delimited record lookup: clock, reset, stimulus, back pressure, verdict.
module delimited_record_lookup_test;
  timeunit 1ns;
  timeprecision 1ps;
  import drl_pkg::*;

  localparam int ROW_MAX      = 64;
  localparam int PERIOD       = 12;
  localparam int LIMIT_CYCLES = 400_000;
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int STAGE_WORDS  = 64;    // random words per idling stage

  // kind bit of an input word
  localparam logic K_TEXT = 1'b0;
  localparam logic K_END  = 1'b1;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // in_tdata: [7:0] text_byte; in_tuser: [0] kind
  logic [7:0]         in_tdata  = '0;
  logic               in_tuser  = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  // out_tdata: [7:0] row_byte; out_tuser: [2:0] status, [3] field_end
  logic [7:0]         out_tdata;
  logic [3:0]         out_tuser;
  logic               out_tlast;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic               cfg_we     = 1'b0;
  logic [CFG_A_W-1:0] cfg_addr   = CFG_SEP;
  logic [63:0]        cfg_wdata  = '0;

  int unsigned fail_count, pending;

  delimited_record_lookup #(.ROW_MAX(ROW_MAX)) DUT (.*);

  drl_lookup_checker #(.ROW_MAX(ROW_MAX)) watch (.*);

  always #(PERIOD/2) clk = ~clk;

  // Hard stop in case the block hangs or drops words.
  initial begin
    #(LIMIT_CYCLES * PERIOD);
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver. Random ready at the falling edge; a bump of hold_reqs from the
  // stimulus starts a long hold-off that is counted down here.
  // ---------------------------------------------------------------------------
  int unsigned send_idle_pct = 18;
  int unsigned recv_idle_pct = 70;
  int unsigned hold_reqs = 0, hold_seen = 0, hold_left = 0;

  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus side. The current register values are kept here only to shape the
  // text (where the delimiters and the reference bytes go).
  // ---------------------------------------------------------------------------
  logic [7:0]   cur_sep   = 8'd35;
  logic [7:0]   cur_delim = 8'd124;
  logic [3:0]   cur_col   = 4'd0;
  logic [4:0]   cur_rlen  = 5'd1;
  logic [127:0] cur_ref   = '0;

  logic [8:0]  text_q[$];   // {kind, byte} per word
  int unsigned words_sent = 0;

  function automatic logic [7:0] any_but(logic [7:0] a, logic [7:0] c);
    logic [7:0] v;
    v = 8'($urandom_range(255));
    while (v == a || v == c) v = 8'($urandom_range(255));
    return v;
  endfunction

  // one word; starts and ends at a falling edge, valid stays up for the next one
  task automatic put_word(logic [8:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tuser  <= w[8];
    in_tdata  <= w[7:0];
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[j]) put_word(text_q[j]);
  endtask

  // Drop valid, wait for every due word, then let the block settle so that a
  // trailing no-result word has been digested before registers change.
  task automatic quiesce();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic put_reg(logic [CFG_A_W-1:0] a, logic [63:0] d);
    cfg_we    <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= d;
    @(negedge clk);
  endtask

  // random noise above the register width, the block must ignore it
  function automatic logic [63:0] noisy(logic [63:0] v, int unsigned w);
    logic [63:0] n;
    n = {$urandom, $urandom};
    return (n << w) | v;
  endfunction

  // Register sets rotate through extremes: sep/delim at 0x00/0xFF, last column,
  // reference length zero, 16 and past 16.
  task automatic pick_setup(int unsigned k);
    logic [7:0]   s, d;
    logic [3:0]   c;
    logic [4:0]   l;
    logic [127:0] r;
    s = 8'($urandom_range(255));
    d = any_but(s, s);
    c = 4'($urandom_range(3));
    l = 5'($urandom_range(1, 17));
    case (k)
      0: begin
        s = 8'h00;
        d = 8'hFF;
        l = 5'd16;
      end
      1: begin
        c = 4'd15;
        l = 5'd1;
      end
      2: begin
        s = 8'hFF;
        d = 8'h00;
        c = 4'($urandom_range(15));
        l = 5'd0;
      end
      3: l = 5'd31;
      default: ;
    endcase
    // reference bytes never equal the delimiter, or no field could match
    for (int i = 0; i < 16; i++) r[i*8 +: 8] = any_but(d, d);
    cur_sep   = s;
    cur_delim = d;
    cur_col   = c;
    cur_rlen  = l;
    cur_ref   = r;
    put_reg(CFG_SEP,      noisy(s, 8));
    put_reg(CFG_DELIM,    noisy(d, 8));
    put_reg(CFG_COLUMN,   noisy(c, 4));
    put_reg(CFG_REF_LEN,  noisy(l, 5));
    put_reg(CFG_REF_LOW,  r[63:0]);
    put_reg(CFG_REF_HIGH, r[127:64]);
    cfg_we <= 1'b0;
  endtask

  task automatic push_text(logic [7:0] b);
    text_q.push_back({K_TEXT, b});
  endtask

  // Field f of a row. The compared field gets the reference (match_pct of the
  // time), sometimes with a near miss: one byte short, one too many, one wrong.
  task automatic add_field(int unsigned f, bit want);
    int unsigned used, k, len;
    used = (cur_rlen > REF_MAX) ? REF_MAX : cur_rlen;
    push_text(cur_delim);
    if (f == cur_col && want && used != 0) begin
      for (k = 0; k < used; k++) push_text(cur_ref[k*8 +: 8]);
      case ($urandom_range(9))
        0: void'(text_q.pop_back());
        1: push_text(any_but(cur_delim, cur_delim));
        2: begin
          k = text_q.size() - 1 - $urandom_range(used - 1);
          text_q[k] = {K_TEXT, any_but(cur_delim, text_q[k][7:0])};
        end
        default: ;
      endcase
    end else begin
      // now and then a field long enough to overflow the row buffer
      len = ($urandom_range(59) == 0) ? $urandom_range(58, 70) : $urandom_range(3);
      repeat (len) push_text(any_but(cur_delim, cur_delim));
    end
    push_text(cur_delim);
  endtask

  // A whole text: mostly well-formed rows with random content, a few empty or
  // junk-only texts, stray bytes between rows, and sometimes an open field
  // at the end.
  task automatic make_text(int unsigned match_pct);
    int unsigned r, rows, nf, i, f;
    bit want;
    text_q.delete();
    r = $urandom_range(99);
    if (r < 4) begin
      // empty text
    end else if (r < 8) begin
      repeat ($urandom_range(1, 4)) push_text(any_but(cur_delim, cur_delim));
    end else begin
      repeat ($urandom_range(2)) push_text(any_but(cur_delim, cur_delim));
      rows = $urandom_range(1, 3);
      for (i = 0; i < rows; i++) begin
        want = $urandom_range(99) < match_pct;
        nf = $urandom_range(1) ? cur_col + 1 + $urandom_range(1) : $urandom_range(1, 4);
        for (f = 0; f < nf; f++) begin
          if (f != 0) begin
            push_text(cur_sep);
            // bytes between separator and opening delimiter stay in the row
            if ($urandom_range(3) == 0)
              repeat ($urandom_range(1, 2)) push_text(any_but(cur_delim, cur_delim));
          end
          add_field(f, want);
        end
        // row end: a non-separator plus junk, or straight into the next delimiter
        if ($urandom_range(2) != 0) begin
          push_text(any_but(cur_sep, cur_delim));
          repeat ($urandom_range(2)) push_text(any_but(cur_delim, cur_delim));
        end
      end
      if ($urandom_range(9) == 0) begin
        push_text(cur_delim);
        repeat ($urandom_range(3)) push_text(any_but(cur_delim, cur_delim));
      end
    end
    text_q.push_back({K_END, 8'($urandom)});
  endtask

  initial begin : stimulus
    int unsigned k, stage, goal;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words with the reset registers ('#' separator, '|' delimiter,
    // column 0, one reference byte 0x00).
    text_q = '{
      {K_END, 8'h5A},                                     // empty text
      {K_TEXT, "x"}, {K_END, 8'h00},                      // junk, no delimiter
      {K_TEXT, "|"}, {K_TEXT, 8'h00}, {K_TEXT, "|"},      // field 0 matches
      {K_TEXT, 8'hFF},                                    // non-separator ends row
      {K_TEXT, "|"}, {K_END, 8'hFF},                      // ignored; end gives nothing
      {K_TEXT, "|"}, {K_TEXT, "a"}, {K_TEXT, "b"},
      {K_END, 8'h00},                                     // open field at end
      {K_TEXT, "x"}, {K_TEXT, "|"}, {K_TEXT, 8'h00},      // leading junk dropped
      {K_TEXT, "|"}, {K_TEXT, "#"}, {K_TEXT, "k"},        // gap byte kept
      {K_TEXT, "|"}, {K_TEXT, "z"}, {K_TEXT, "|"},
      {K_END, 8'h00}                                      // matched row sent at end
    };
    send_text();

    k = 0;
    for (stage = 0; stage < 3; stage++) begin
      quiesce();
      case (stage)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct <= 70;
        end
        1: begin
          send_idle_pct = 70;
          recv_idle_pct <= 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
          // Receiver stalls for a long stretch while matching texts keep coming:
          // the job queue fills and the input must back off.
          pick_setup(4);
          hold_reqs <= hold_reqs + 1;
          repeat (2) begin
            make_text(100);
            send_text();
          end
        end
      endcase
      goal = words_sent + STAGE_WORDS;
      while (words_sent < goal) begin
        quiesce();
        pick_setup(k % 5);
        k++;
        make_text(50);
        send_text();
      end
    end

    quiesce();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
